>>> design/mse_pkg.sv
// mse_pkg: shared types and constants for the mips subset executor
// depends on nothing
`default_nettype none
package mse_pkg;
	localparam int unsigned MemDepth = 256;
	localparam int unsigned NumRegs  = 32;

	typedef enum logic [1:0] {
		FUNC_STEP = 2'd0,
		FUNC_LOAD = 2'd1,
		FUNC_WREG = 2'd2,
		FUNC_SETPC = 2'd3
	} func_t;

	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_INSN  = 2'd2;

	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_BNE   = 6'd5;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_SW    = 6'd43;

	localparam logic [5:0] FN_ADD  = 6'd32;
	localparam logic [5:0] FN_SUB  = 6'd34;
	localparam logic [5:0] FN_MULT = 6'd24;
	localparam logic [5:0] FN_DIV  = 6'd26;

	localparam logic [4:0] REG_LO = 5'd24;
	localparam logic [4:0] REG_HI = 5'd25;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DIVZ   = 2'd1;
	localparam logic [1:0] ST_NOINSN = 2'd2;

	// one memory word: kind tag, value, decoded instruction fields
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] value;
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  rd;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [7:0]  imm;
	} entry_t;
endpackage
`default_nettype wire

>>> design/mips_subset_instruction_executor.sv
// mips_subset_instruction_executor: sequencer, register file, tagged memory
// and one shared add/subtract unit used for add, sub, shift-add mult and div
// depends on mse_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one request per item: a step,
//   a memory entry load, a register write or a pc set. output channel
//   (out_valid/out_ready) returns exactly one result per request.
// sequence:
//   a non-step request goes from S_IDLE straight to S_DONE. a step passes
//   S_FETCH, S_DECODE and S_RDREG; a jump, branch, non-instruction entry,
//   divide by zero or unknown code then goes to S_DONE, add and sub pass
//   S_ITER, lw passes S_LWRD and S_LWDONE, sw passes S_SWRD, and mult and div
//   take 32 iterations of the one adder in S_ITER, then S_FIX. the next
//   request is taken in the cycle after the result is loaded, not before.
// reset:
//   pc and registers clear at once. memory tags are cleared by a pass over
//   all MEM_DEPTH entries after reset, one entry a cycle, during which no
//   request is accepted.
// stalls:
//   a held result stays in the output register until taken; the next
//   request is still accepted and worked on, and its result waits for it.
`default_nettype none
module mips_subset_instruction_executor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  address,
	input  wire logic [1:0]  entry_kind,
	input  wire logic signed [31:0] word_value,
	input  wire logic [5:0]  opcode,
	input  wire logic [5:0]  funct,
	input  wire logic [4:0]  dest_reg,
	input  wire logic [4:0]  src1_reg,
	input  wire logic [4:0]  src2_reg,
	input  wire logic [7:0]  immediate,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       next_pc,
	output logic             reg_written,
	output logic [4:0]       reg_index,
	output logic signed [31:0] reg_value,
	output logic             rem_written,
	output logic signed [31:0] rem_value,
	output logic             mem_written,
	output logic [7:0]       mem_address,
	output logic signed [31:0] mem_value,
	output logic [1:0]       status
);
	localparam int unsigned MEM_DEPTH = mse_pkg::MemDepth;
	localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_RDREG, S_ITER, S_FIX,
		S_LWRD, S_LWDONE, S_SWRD, S_DONE
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q, pc_q, maddr;
	mse_pkg::entry_t mem [MEM_DEPTH];
	mse_pkg::entry_t rdata_q, ins_q;
	logic [31:0] regs_q [mse_pkg::NumRegs];
	logic [31:0] a_q, b_q, acc_q, quo_q;
	logic [5:0] cnt_q;
	logic na_q, nb_q;
	logic [AW-1:0] npc_q;
	// working result fields
	logic rw_q, mw_q, hw_q;
	logic [4:0] ri_q;
	logic [31:0] rval_q, hval_q, mval_q;
	logic [7:0] ma_q;
	logic [1:0] st_q;
	// output register
	logic rv_q, orw_q, omw_q, ohw_q;
	logic [4:0] ori_q;
	logic [31:0] orval_q, ohval_q, omval_q;
	logic [7:0] oma_q, opc_q;
	logic [1:0] ost_q;

	// shared adder: one wide add, second operand optionally inverted
	logic [31:0] add_x, add_y;
	logic add_sub;
	logic [32:0] add_o;
	assign add_o = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y} + 33'(add_sub);

	// divide remainder shifted in with next dividend bit
	logic [32:0] rem_sh;
	assign rem_sh = {acc_q, a_q[31]};

	always_comb begin
		add_x = a_q;
		add_y = b_q;
		add_sub = 1'b0;
		unique case (state_q)
			S_ITER: begin
				if (ins_q.fn == mse_pkg::FN_DIV) begin
					add_x = rem_sh[31:0];
					add_y = b_q;
					add_sub = 1'b1;
				end else if (ins_q.fn == mse_pkg::FN_MULT) begin
					add_x = acc_q;
					add_y = b_q;
				end else begin
					add_sub = (ins_q.fn == mse_pkg::FN_SUB);
				end
			end
			S_FIX: begin
				add_x = 32'd0;
				add_y = quo_q;
				add_sub = 1'b1;
			end
			default: begin
				add_sub = (ins_q.fn == mse_pkg::FN_SUB);
			end
		endcase
	end

	logic in_fire, out_fire;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_comb begin
		maddr = pc_q;
		if (state_q == S_LWRD || state_q == S_SWRD)
			maddr = ins_q.imm[AW-1:0];
	end

	// memory: tag clear pass, loads, stores and the fetch/lw read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[maddr];
		if (state_q == S_CLEAR)
			mem[clr_q] <= '0;
		else if (in_fire && func == mse_pkg::FUNC_LOAD) begin
			if (entry_kind == mse_pkg::KIND_DATA || entry_kind == mse_pkg::KIND_INSN)
				mem[address[AW-1:0]] <= '{entry_kind, word_value, opcode, funct,
					dest_reg, src1_reg, src2_reg, immediate};
			else
				mem[address[AW-1:0]] <= '0;
		end else if (state_q == S_SWRD)
			mem[ins_q.imm[AW-1:0]] <= '{mse_pkg::KIND_DATA, regs_q[ins_q.rd],
				6'd0, 6'd0, 5'd0, 5'd0, 5'd0, 8'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pc_q <= '0;
			rv_q <= 1'b0;
			for (int i = 0; i < int'(mse_pkg::NumRegs); i++) regs_q[i] <= '0;
		end else begin
			// output register loads from S_DONE once free or being taken
			if (state_q == S_DONE && (!rv_q || out_fire)) rv_q <= 1'b1;
			else if (out_fire) rv_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MEM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						rw_q <= 1'b0; ri_q <= '0; rval_q <= '0;
						hw_q <= 1'b0; hval_q <= '0;
						mw_q <= 1'b0; ma_q <= '0; mval_q <= '0; st_q <= mse_pkg::ST_OK;
						unique case (mse_pkg::func_t'(func))
							mse_pkg::FUNC_STEP: begin
								npc_q <= pc_q + 1'b1;
								state_q <= S_FETCH;
							end
							mse_pkg::FUNC_LOAD: begin
								npc_q <= pc_q;
								state_q <= S_DONE;
							end
							mse_pkg::FUNC_WREG: begin
								if (address < 8'(mse_pkg::NumRegs))
									regs_q[address[4:0]] <= word_value;
								npc_q <= pc_q;
								state_q <= S_DONE;
							end
							mse_pkg::FUNC_SETPC: begin
								npc_q <= address[AW-1:0];
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FETCH: state_q <= S_DECODE;
				S_DECODE: begin
					ins_q <= rdata_q;
					state_q <= S_RDREG;
				end
				S_RDREG: begin
					a_q <= regs_q[ins_q.rs];
					b_q <= regs_q[ins_q.rt];
					acc_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					if (ins_q.kind != mse_pkg::KIND_INSN) begin
						st_q <= mse_pkg::ST_NOINSN;
						state_q <= S_DONE;
					end else if (ins_q.op == mse_pkg::OP_RTYPE) begin
						if (ins_q.fn == mse_pkg::FN_ADD || ins_q.fn == mse_pkg::FN_SUB
							|| ins_q.fn == mse_pkg::FN_MULT || ins_q.fn == mse_pkg::FN_DIV) begin
							state_q <= S_ITER;
							if (ins_q.fn == mse_pkg::FN_DIV) begin
								na_q <= regs_q[ins_q.rs][31];
								nb_q <= regs_q[ins_q.rt][31];
								a_q <= regs_q[ins_q.rs][31] ? 32'(-regs_q[ins_q.rs])
									: regs_q[ins_q.rs];
								b_q <= regs_q[ins_q.rt][31] ? 32'(-regs_q[ins_q.rt])
									: regs_q[ins_q.rt];
								if (regs_q[ins_q.rt] == 32'd0) begin
									st_q <= mse_pkg::ST_DIVZ;
									state_q <= S_DONE;
								end
							end
						end else state_q <= S_DONE;
					end else if (ins_q.op == mse_pkg::OP_LW) state_q <= S_LWRD;
					else if (ins_q.op == mse_pkg::OP_SW) state_q <= S_SWRD;
					else begin
						if (ins_q.op == mse_pkg::OP_J
							|| (ins_q.op == mse_pkg::OP_BEQ
								&& regs_q[ins_q.rs] == regs_q[ins_q.rt])
							|| (ins_q.op == mse_pkg::OP_BNE
								&& regs_q[ins_q.rs] != regs_q[ins_q.rt]))
							npc_q <= ins_q.imm[AW-1:0];
						state_q <= S_DONE;
					end
				end
				S_ITER: begin
					if (ins_q.fn == mse_pkg::FN_ADD || ins_q.fn == mse_pkg::FN_SUB) begin
						rw_q <= 1'b1; ri_q <= ins_q.rd; rval_q <= add_o[31:0];
						regs_q[ins_q.rd] <= add_o[31:0];
						state_q <= S_DONE;
					end else if (ins_q.fn == mse_pkg::FN_MULT) begin
						// shift-add, multiplier bits taken msb first
						a_q <= {a_q[30:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 6'd31) begin
							acc_q <= a_q[31] ? add_o[31:0] : acc_q;
							state_q <= S_FIX;
						end else begin
							acc_q <= a_q[31] ? {add_o[30:0], 1'b0} : {acc_q[30:0], 1'b0};
						end
					end else begin
						// restoring divide, one quotient bit a cycle
						a_q <= {a_q[30:0], 1'b0};
						if (rem_sh >= {1'b0, b_q}) begin
							acc_q <= add_o[31:0];
							quo_q <= {quo_q[30:0], 1'b1};
						end else begin
							acc_q <= rem_sh[31:0];
							quo_q <= {quo_q[30:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 6'd31) state_q <= S_FIX;
					end
				end
				S_FIX: begin
					rw_q <= 1'b1; ri_q <= mse_pkg::REG_LO;
					if (ins_q.fn == mse_pkg::FN_MULT) begin
						rval_q <= acc_q;
						regs_q[mse_pkg::REG_LO] <= acc_q;
					end else begin
						rval_q <= (na_q != nb_q) ? add_o[31:0] : quo_q;
						regs_q[mse_pkg::REG_LO] <= (na_q != nb_q) ? add_o[31:0] : quo_q;
						hw_q <= 1'b1;
						hval_q <= na_q ? 32'(-acc_q) : acc_q;
						regs_q[mse_pkg::REG_HI] <= na_q ? 32'(-acc_q) : acc_q;
					end
					state_q <= S_DONE;
				end
				S_LWRD: state_q <= S_LWDONE;
				S_LWDONE: begin
					rw_q <= 1'b1; ri_q <= ins_q.rd;
					rval_q <= (rdata_q.kind == mse_pkg::KIND_DATA) ? rdata_q.value : '0;
					regs_q[ins_q.rd] <= (rdata_q.kind == mse_pkg::KIND_DATA)
						? rdata_q.value : '0;
					state_q <= S_DONE;
				end
				S_SWRD: begin
					mw_q <= 1'b1; ma_q <= 8'(ins_q.imm[AW-1:0]);
					mval_q <= regs_q[ins_q.rd];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rv_q || out_fire) begin
						pc_q <= npc_q;
						opc_q <= 8'(npc_q);
						orw_q <= rw_q; ori_q <= ri_q; orval_q <= rval_q;
						ohw_q <= hw_q; ohval_q <= hval_q;
						omw_q <= mw_q; oma_q <= ma_q; omval_q <= mval_q;
						ost_q <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = rv_q;
	assign next_pc     = opc_q;
	assign reg_written = orw_q;
	assign reg_index   = ori_q;
	assign reg_value   = orval_q;
	assign rem_written = ohw_q;
	assign rem_value   = ohval_q;
	assign mem_written = omw_q;
	assign mem_address = oma_q;
	assign mem_value   = omval_q;
	assign status      = ost_q;

	// no request taken during the clearing pass
	a_noclr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready) else $error("accept during clear");
	// remainder written only with quotient to register 24
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && ohw_q |-> orw_q && ori_q == mse_pkg::REG_LO) else $error("rem alone");
	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && !out_ready |=> rv_q && $stable(orval_q)) else $error("result lost");
endmodule
`default_nettype wire

>>> dv/mse_checker.sv
// mse_checker: watches both channels of the mips subset executor, predicts each result
// from its own copy of pc, registers and tagged memory, and counts mismatches
// depends on mse_pkg
module mse_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  address,
	input  wire logic [1:0]  entry_kind,
	input  wire logic [31:0] word_value,
	input  wire logic [5:0]  opcode,
	input  wire logic [5:0]  funct,
	input  wire logic [4:0]  dest_reg,
	input  wire logic [4:0]  src1_reg,
	input  wire logic [4:0]  src2_reg,
	input  wire logic [7:0]  immediate,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  next_pc,
	input  wire logic        reg_written,
	input  wire logic [4:0]  reg_index,
	input  wire logic [31:0] reg_value,
	input  wire logic        rem_written,
	input  wire logic [31:0] rem_value,
	input  wire logic        mem_written,
	input  wire logic [7:0]  mem_address,
	input  wire logic [31:0] mem_value,
	input  wire logic [1:0]  status,
	output int               failures,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  pc;
		logic        rw;
		logic [4:0]  ri;
		logic [31:0] rv;
		logic        hw;
		logic [31:0] hv;
		logic        mw;
		logic [7:0]  ma;
		logic [31:0] mv;
		logic [1:0]  st;
	} outcome_t;

	outcome_t         expected_q[$];
	logic [7:0]       pc_model;
	logic [31:0]      regs_model[mse_pkg::NumRegs];
	mse_pkg::entry_t  mem_model[mse_pkg::MemDepth];

	function automatic void divide_signed(input logic [31:0] a, input logic [31:0] b,
		output logic [31:0] q, output logic [31:0] r);
		logic [31:0] ma, mb;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (a[31] != b[31]) q = -q;
		if (a[31]) r = -r;
	endfunction

	task automatic execute_request();
		outcome_t o;
		mse_pkg::entry_t e;
		logic [31:0] a, b, q, r;
		o = '0;
		o.pc = pc_model;
		case (mse_pkg::func_t'(func))
			mse_pkg::FUNC_LOAD: begin
				e = '0;
				if (entry_kind == mse_pkg::KIND_DATA || entry_kind == mse_pkg::KIND_INSN)
					e = '{entry_kind, word_value, opcode, funct, dest_reg, src1_reg,
						src2_reg, immediate};
				mem_model[address] = e;
			end
			mse_pkg::FUNC_WREG: begin
				if (address < mse_pkg::NumRegs) regs_model[address[4:0]] = word_value;
			end
			mse_pkg::FUNC_SETPC: o.pc = address;
			default: begin
				e = mem_model[pc_model];
				o.pc = pc_model + 8'd1;
				if (e.kind != mse_pkg::KIND_INSN) begin
					o.st = mse_pkg::ST_NOINSN;
				end else begin
					a = regs_model[e.rs];
					b = regs_model[e.rt];
					if (e.op == mse_pkg::OP_RTYPE) begin
						if (e.fn == mse_pkg::FN_ADD) begin
							o.rw = 1'b1; o.ri = e.rd; o.rv = a + b;
						end else if (e.fn == mse_pkg::FN_SUB) begin
							o.rw = 1'b1; o.ri = e.rd; o.rv = a - b;
						end else if (e.fn == mse_pkg::FN_MULT) begin
							o.rw = 1'b1; o.ri = mse_pkg::REG_LO; o.rv = a * b;
						end else if (e.fn == mse_pkg::FN_DIV) begin
							if (b == 32'd0) begin
								o.st = mse_pkg::ST_DIVZ;
							end else begin
								divide_signed(a, b, q, r);
								o.rw = 1'b1; o.ri = mse_pkg::REG_LO; o.rv = q;
								o.hw = 1'b1; o.hv = r;
							end
						end
					end else if (e.op == mse_pkg::OP_J) begin
						o.pc = e.imm;
					end else if (e.op == mse_pkg::OP_BEQ) begin
						if (a == b) o.pc = e.imm;
					end else if (e.op == mse_pkg::OP_BNE) begin
						if (a != b) o.pc = e.imm;
					end else if (e.op == mse_pkg::OP_LW) begin
						o.rw = 1'b1; o.ri = e.rd;
						o.rv = (mem_model[e.imm].kind == mse_pkg::KIND_DATA)
							? mem_model[e.imm].value : '0;
					end else if (e.op == mse_pkg::OP_SW) begin
						o.mw = 1'b1; o.ma = e.imm; o.mv = regs_model[e.rd];
						mem_model[e.imm] = '{mse_pkg::KIND_DATA, o.mv, 6'd0, 6'd0, 5'd0,
							5'd0, 5'd0, 8'd0};
					end
					if (o.rw) regs_model[o.ri] = o.rv;
					if (o.hw) regs_model[mse_pkg::REG_HI] = o.hv;
				end
			end
		endcase
		pc_model = o.pc;
		expected_q.push_back(o);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t mismatch %s expected %0h actual %0h", $time, name, exp, act);
			failures++;
		end
	endtask

	task automatic check_result();
		outcome_t o;
		if (expected_q.size() == 0) begin
			$display("%0t unexpected result, next_pc %0h", $time, next_pc);
			failures++;
		end else begin
			o = expected_q.pop_front();
			compare_field("next_pc", 32'(o.pc), 32'(next_pc));
			compare_field("reg_written", 32'(o.rw), 32'(reg_written));
			compare_field("reg_index", 32'(o.ri), 32'(reg_index));
			compare_field("reg_value", o.rv, reg_value);
			compare_field("rem_written", 32'(o.hw), 32'(rem_written));
			compare_field("rem_value", o.hv, rem_value);
			compare_field("mem_written", 32'(o.mw), 32'(mem_written));
			compare_field("mem_address", 32'(o.ma), 32'(mem_address));
			compare_field("mem_value", o.mv, mem_value);
			compare_field("status", 32'(o.st), 32'(status));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			failures = 0;
			pc_model = '0;
			foreach (regs_model[i]) regs_model[i] = '0;
			foreach (mem_model[i]) mem_model[i] = '0;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) check_result();
			if (in_valid && in_ready) execute_request();
		end
		pending <= expected_q.size();
	end
endmodule

>>> dv/testbench.sv
// testbench: stimulus and verdict for mips_subset_instruction_executor
// builds programs in the tagged memory, steps them and lets mse_checker judge results
// depends on mse_pkg, mse_checker and the block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [7:0]  address = '0;
	logic [1:0]  entry_kind = '0;
	logic [31:0] word_value = '0;
	logic [5:0]  opcode = '0;
	logic [5:0]  funct = '0;
	logic [4:0]  dest_reg = '0;
	logic [4:0]  src1_reg = '0;
	logic [4:0]  src2_reg = '0;
	logic [7:0]  immediate = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [7:0]  next_pc;
	logic        reg_written;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        rem_written;
	logic [31:0] rem_value;
	logic        mem_written;
	logic [7:0]  mem_address;
	logic [31:0] mem_value;
	logic [1:0]  status;
	int          failures;
	int          pending;
	int          cycles = 0;
	bit          calm = 0;    // last stretch of the run, no idling

	mips_subset_instruction_executor uut (.*);
	mse_checker checker_i (.*);

	// 10 ns clock
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// watchdog: allows for the worst step, output stalls and the clearing pass
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side backpressure in random bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			out_ready <= 1;
			n = $urandom_range(1, 20);
			repeat (n) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// one request, held until accepted; random gap before it
	task automatic send_request(input mse_pkg::func_t f, input logic [7:0] a,
		input logic [1:0] k, input logic [31:0] v, input logic [5:0] op,
		input logic [5:0] fn, input logic [4:0] rd, input logic [4:0] rs,
		input logic [4:0] rt, input logic [7:0] imm);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1;
		func <= f; address <= a; entry_kind <= k; word_value <= v;
		opcode <= op; funct <= fn; dest_reg <= rd; src1_reg <= rs; src2_reg <= rt;
		immediate <= imm;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic put_insn(input logic [7:0] a, input logic [5:0] op, input logic [5:0] fn,
		input logic [4:0] rd, input logic [4:0] rs, input logic [4:0] rt,
		input logic [7:0] imm);
		send_request(mse_pkg::FUNC_LOAD, a, mse_pkg::KIND_INSN, $urandom, op, fn, rd, rs,
			rt, imm);
	endtask

	task automatic set_reg(input logic [7:0] r, input logic [31:0] v);
		send_request(mse_pkg::FUNC_WREG, r, 2'($urandom), v, 6'($urandom), 6'($urandom),
			5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
	endtask

	task automatic step_once();
		send_request(mse_pkg::FUNC_STEP, 8'($urandom), 2'($urandom), $urandom,
			6'($urandom), 6'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
			8'($urandom));
	endtask

	task automatic set_pc(input logic [7:0] a);
		send_request(mse_pkg::FUNC_SETPC, a, 2'($urandom), $urandom, 6'($urandom),
			6'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
	endtask

	// a random operand, biased toward corner values
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [5:0] pick_opcode();
		case ($urandom_range(0, 9))
			0, 1, 2: return mse_pkg::OP_RTYPE;
			3: return mse_pkg::OP_J;
			4: return mse_pkg::OP_BEQ;
			5: return mse_pkg::OP_BNE;
			6: return mse_pkg::OP_LW;
			7: return mse_pkg::OP_SW;
			default: return 6'($urandom);
		endcase
	endfunction

	function automatic logic [5:0] pick_funct();
		case ($urandom_range(0, 4))
			0: return mse_pkg::FN_ADD;
			1: return mse_pkg::FN_SUB;
			2: return mse_pkg::FN_MULT;
			3: return mse_pkg::FN_DIV;
			default: return 6'($urandom);
		endcase
	endfunction

	int total = 0;

	initial begin
		int n;
		logic [7:0] base;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: step of an empty entry, then every operation with corner operands
		step_once();
		set_reg(8'd1, 32'h8000_0000);
		set_reg(8'd2, 32'hFFFF_FFFF);
		set_reg(8'd0, 32'd7);             // register zero is writable
		set_reg(8'd200, 32'hDEAD_BEEF);   // index beyond the file, ignored
		put_insn(8'd1, mse_pkg::OP_RTYPE, mse_pkg::FN_DIV, 5'd3, 5'd1, 5'd2, 8'd0);
		put_insn(8'd2, mse_pkg::OP_RTYPE, mse_pkg::FN_DIV, 5'd3, 5'd1, 5'd31, 8'd0);
		put_insn(8'd3, mse_pkg::OP_RTYPE, mse_pkg::FN_MULT, 5'd3, 5'd1, 5'd2, 8'd0);
		put_insn(8'd4, mse_pkg::OP_RTYPE, mse_pkg::FN_ADD, 5'd4, 5'd1, 5'd2, 8'd0);
		put_insn(8'd5, mse_pkg::OP_RTYPE, mse_pkg::FN_SUB, 5'd5, 5'd0, 5'd2, 8'd0);
		put_insn(8'd6, mse_pkg::OP_SW, 6'd0, 5'd5, 5'd0, 5'd0, 8'd255);
		put_insn(8'd7, mse_pkg::OP_LW, 6'd0, 5'd6, 5'd0, 5'd0, 8'd255);
		put_insn(8'd8, mse_pkg::OP_LW, 6'd0, 5'd7, 5'd0, 5'd0, 8'd1);  // instruction reads 0
		put_insn(8'd9, mse_pkg::OP_BEQ, 6'd0, 5'd0, 5'd9, 5'd10, 8'd12);
		send_request(mse_pkg::FUNC_LOAD, 8'd10, 2'd3, 32'h1234, 6'h3F, 6'h3F, 5'h1F, 5'h1F,
			5'h1F, 8'hFF);                                            // kind three, empty
		put_insn(8'd12, mse_pkg::OP_BNE, 6'd0, 5'd0, 5'd1, 5'd2, 8'd254);
		put_insn(8'd254, 6'h3F, 6'h3F, 5'h1F, 5'h1F, 5'h1F, 8'hFF);  // unknown opcode
		put_insn(8'd255, mse_pkg::OP_J, 6'd0, 5'd0, 5'd0, 5'd0, 8'd0); // pc wraps
		set_pc(8'd1);
		repeat (14) step_once();
		total = 32;

		// random: small programs with random content, then steps through them, plus noise
		while (total < 1150) begin
			if (total > 1050) calm = 1;
			case ($urandom_range(0, 9))
				0: begin
					send_request(mse_pkg::FUNC_LOAD, 8'($urandom), 2'($urandom), $urandom,
						6'($urandom), 6'($urandom), 5'($urandom), 5'($urandom),
						5'($urandom), 8'($urandom));
					total++;
				end
				1: begin
					set_pc(8'($urandom));
					total++;
				end
				default: begin
					base = 8'($urandom_range(0, 255));
					n = $urandom_range(2, 8);
					for (int i = 0; i < 3; i++)
						set_reg(8'($urandom_range(0, 31)), pick_value());
					for (int i = 0; i < n; i++)
						put_insn(8'(base + i), pick_opcode(), pick_funct(), 5'($urandom),
							5'($urandom), 5'($urandom),
							($urandom_range(0, 3) == 0) ? base : 8'($urandom));
					if ($urandom_range(0, 1)) begin
						send_request(mse_pkg::FUNC_LOAD, 8'(base + n), mse_pkg::KIND_DATA,
							pick_value(), 6'($urandom), 6'($urandom), 5'($urandom),
							5'($urandom), 5'($urandom), 8'($urandom));
						total++;
					end
					set_pc(base);
					for (int i = 0; i < n + 2; i++) step_once();
					total += 3 + n + 1 + n + 2;
				end
			endcase
		end
		in_valid <= 0;

		// drain outstanding results, then a short settle
		while (pending != 0 || out_valid) @(posedge clk);
		repeat (50) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> sim.f
design/mse_pkg.sv
design/mips_subset_instruction_executor.sv
dv/mse_checker.sv
dv/testbench.sv
